@@ rtl/fir_pkg.sv @@
`timescale 1ns / 1ps

package fir_pkg;

    localparam int TAPS_DEFAULT = 32;
    localparam int SAMPLE_W     = 16;
    localparam int INDEX_W      = 5;
    localparam int PROD_W       = 2 * SAMPLE_W;
    localparam int ACC_W        = 37;

    localparam logic ACT_COEF   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic                       action;
        logic [INDEX_W-1:0]         tap_index;
        logic signed [SAMPLE_W-1:0] tap_value;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] filtered;
        logic                    window_full;
        logic                    last_out;
    } out_t;

    typedef struct packed {
        logic shift;
        logic coef_we;
    } cell_ctrl_t;

    typedef struct packed {
        logic                    go;
        logic signed [ACC_W-1:0] acc;
    } sum_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  a,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W + 1 - PROD_W){p[PROD_W-1]}}, p};
        if (s[ACC_W] != s[ACC_W-1]) begin
            if (s[ACC_W]) begin
                return {1'b1, {(ACC_W - 1){1'b0}}};
            end else begin
                return {1'b0, {(ACC_W - 1){1'b1}}};
            end
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

@@ rtl/fir_cell.sv @@
`timescale 1ns / 1ps

module fir_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fir_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] sample_in,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] tap_in,
    output logic signed [fir_pkg::SAMPLE_W-1:0] sample_out,
    input  fir_pkg::sum_t                       sum_in,
    output fir_pkg::sum_t                       sum_out
);
    import fir_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [SAMPLE_W-1:0] coef_reg, coef_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    sum_t                       sum_reg, sum_next;

    always_comb begin
        sample_next = ctrl.shift ? sample_in : sample_reg;
        coef_next   = ctrl.coef_we ? tap_in : coef_reg;
        prod_next   = prod_reg;
        if (ctrl.shift) begin
            // product of the window before the shift
            prod_next = sample_reg * coef_reg;
        end
        sum_next.go  = sum_in.go;
        sum_next.acc = sum_in.go ? sat_add(sum_in.acc, prod_reg) : sum_reg.acc;
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        sum_reg.acc  <= sum_next.acc;
        if (!aresetn) begin
            sample_reg <= '0;
            coef_reg   <= '0;
            sum_reg.go <= 1'b0;
        end else begin
            sample_reg <= sample_next;
            coef_reg   <= coef_next;
            sum_reg.go <= sum_next.go;
        end
    end

    assign sample_out = sample_reg;
    assign sum_out    = sum_reg;

endmodule

@@ rtl/fir_filter_stream.sv @@
`timescale 1ns / 1ps

// Direct-form FIR filter built as a row of TAPS cells, each holding one delay-line sample,
// one coefficient and one registered product. A coefficient request writes the coefficient
// of the cell named by tap_index and gives no result. A sample request captures all products
// and shifts the delay line at once; the partial sum then walks the row one cell per cycle,
// adding and saturating in each, then passes a pending register into the output register,
// and s_ready stays low until then. A new sample is therefore accepted only after the previous
// result reached the output register, which the length of the sum chain sets, and a result
// held there while m_ready is low delays it further. Results are zero with window_full low for
// the first TAPS samples.

module fir_filter_stream #(
    parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fir_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output fir_pkg::out_t m_data
);
    import fir_pkg::*;

    localparam int FILL_W = $clog2(TAPS + 1);

    logic              busy_reg, busy_next;
    logic              start_reg, start_next;
    logic              full_reg, full_next;
    logic              last_reg, last_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              pend_valid_reg, pend_valid_next;
    out_t              pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic in_acc, sample_acc, coef_acc, window_now, pend_move;

    logic signed [SAMPLE_W-1:0] sample_chain [0:TAPS];
    sum_t                       sum_chain [0:TAPS];
    cell_ctrl_t                 cell_ctrl [0:TAPS-1];

    assign s_ready    = !busy_reg;
    assign in_acc     = s_valid && s_ready;
    assign sample_acc = in_acc && (s_data.action == ACT_SAMPLE);
    assign coef_acc   = in_acc && (s_data.action == ACT_COEF);
    assign window_now = (fill_reg == FILL_W'(TAPS));
    assign pend_move  = pend_valid_reg && (!m_valid_reg || m_ready);

    assign sample_chain[TAPS] = s_data.sample;
    assign sum_chain[0]       = '{go: start_reg, acc: '0};

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        assign cell_ctrl[k] = '{shift: sample_acc,
                                coef_we: coef_acc && (int'(s_data.tap_index) == k)};

        fir_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl[k]),
            .sample_in  (sample_chain[k+1]),
            .tap_in     (s_data.tap_value),
            .sample_out (sample_chain[k]),
            .sum_in     (sum_chain[k]),
            .sum_out    (sum_chain[k+1])
        );
    end

    always_comb begin
        busy_next       = busy_reg;
        start_next      = sample_acc;
        full_next       = full_reg;
        last_next       = last_reg;
        fill_next       = fill_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (sample_acc) begin
            busy_next = 1'b1;
            full_next = window_now;
            last_next = s_data.last_sample;
            if (!window_now) begin
                fill_next = fill_reg + 1'b1;
            end
        end

        if (sum_chain[TAPS].go) begin
            pend_valid_next       = 1'b1;
            pend_next.filtered    = full_reg ? sum_chain[TAPS].acc : '0;
            pend_next.window_full = full_reg;
            pend_next.last_out    = last_reg;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pend_move) begin
            m_valid_next    = 1'b1;
            m_data_next     = pend_reg;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        full_reg   <= full_next;
        last_reg   <= last_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            start_reg      <= 1'b0;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            start_reg      <= start_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
